### rtl/core/pns_pkg.sv
// Shared types and constants for the perception noise step block.
// Used by pns_ctrl, pns_dp and perception_noise_step; depends on nothing.
package pns_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_DECAY_GAP  = 3'd1;
  localparam logic [2:0] REG_DECAY_RATE = 3'd2;
  localparam logic [2:0] REG_AMP_GAP    = 3'd3;
  localparam logic [2:0] REG_AMP_RATE   = 3'd4;
  localparam logic [2:0] REG_AMP_ACCEL  = 3'd5;
  localparam logic [2:0] REG_GAP_VAR    = 3'd6;
  localparam logic [2:0] REG_INV_TTC    = 3'd7;

  localparam int IN_W  = 144;
  localparam int OUT_W = 96;

  localparam logic signed [50:0] LN2_Q32   = 51'sd2977044472;
  localparam logic signed [50:0] HALF_LN2  = 51'sd1488522236;
  localparam logic signed [63:0] ONE_Q32   = 64'sd4294967296;
  localparam logic signed [33:0] X_HI      = 34'sd720896;
  localparam logic signed [33:0] X_LO      = -34'sd786432;
  localparam logic signed [31:0] HELD_INIT = 32'sd655360;
  localparam logic signed [16:0] C_BIAS    = 17'sd32768;
  localparam logic [3:0]         N_LAST    = 4'd12;
  localparam logic [3:0]         N_FIRST   = 4'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MA, OP_MDR, OP_MAR, OP_MDG, OP_MAG, OP_GNW, OP_MX,
    OP_KINIT, OP_KRED, OP_RINIT, OP_TM, OP_DIVS, OP_DIV, OP_TADD, OP_EXPO,
    OP_GM, OP_GW, OP_TW, OP_RH, OP_RL, OP_RW
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MA, ST_MDR, ST_MAR, ST_MDG, ST_MAG, ST_GNW, ST_MX, ST_KINIT,
    ST_KRED, ST_RINIT, ST_TM, ST_DIVS, ST_DIV, ST_TADD, ST_EXPO, ST_GM, ST_GW,
    ST_TW, ST_RH, ST_RL, ST_RW
  } st_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic kdone;
    logic div_last;
    logic term_last;
  } status_t;

endpackage

### rtl/core/pns_ctrl.sv
// Sequencer for the perception noise step: walks the datapath through one item.
// Depends on pns_pkg for state, command and status types.
module pns_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  pns_pkg::status_t stat,
  output pns_pkg::cmd_t    cmd
);

  pns_pkg::st_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == pns_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pns_pkg::ST_IDLE:  if (in_tvalid) state_nxt = pns_pkg::ST_MA;
      pns_pkg::ST_MA:    state_nxt = pns_pkg::ST_MDR;
      pns_pkg::ST_MDR:   state_nxt = pns_pkg::ST_MAR;
      pns_pkg::ST_MAR:   state_nxt = pns_pkg::ST_MDG;
      pns_pkg::ST_MDG:   state_nxt = pns_pkg::ST_MAG;
      pns_pkg::ST_MAG:   state_nxt = pns_pkg::ST_GNW;
      pns_pkg::ST_GNW:   state_nxt = pns_pkg::ST_MX;
      pns_pkg::ST_MX:    state_nxt = pns_pkg::ST_KINIT;
      pns_pkg::ST_KINIT: state_nxt = pns_pkg::ST_KRED;
      pns_pkg::ST_KRED:  if (stat.kdone) state_nxt = pns_pkg::ST_RINIT;
      pns_pkg::ST_RINIT: state_nxt = pns_pkg::ST_TM;
      pns_pkg::ST_TM:    state_nxt = pns_pkg::ST_DIVS;
      pns_pkg::ST_DIVS:  state_nxt = pns_pkg::ST_DIV;
      pns_pkg::ST_DIV:   if (stat.div_last) state_nxt = pns_pkg::ST_TADD;
      pns_pkg::ST_TADD:  state_nxt = stat.term_last ? pns_pkg::ST_EXPO : pns_pkg::ST_TM;
      pns_pkg::ST_EXPO:  state_nxt = pns_pkg::ST_GM;
      pns_pkg::ST_GM:    state_nxt = pns_pkg::ST_GW;
      pns_pkg::ST_GW:    state_nxt = pns_pkg::ST_TW;
      pns_pkg::ST_TW:    state_nxt = pns_pkg::ST_RH;
      pns_pkg::ST_RH:    state_nxt = pns_pkg::ST_RL;
      pns_pkg::ST_RL:    state_nxt = pns_pkg::ST_RW;
      pns_pkg::ST_RW:    if (out_free) state_nxt = pns_pkg::ST_IDLE;
      default:           state_nxt = pns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = pns_pkg::OP_NONE;
    unique case (state_r)
      pns_pkg::ST_IDLE:  if (in_tvalid) cmd.op = pns_pkg::OP_LOAD;
      pns_pkg::ST_MA:    cmd.op = pns_pkg::OP_MA;
      pns_pkg::ST_MDR:   cmd.op = pns_pkg::OP_MDR;
      pns_pkg::ST_MAR:   cmd.op = pns_pkg::OP_MAR;
      pns_pkg::ST_MDG:   cmd.op = pns_pkg::OP_MDG;
      pns_pkg::ST_MAG:   cmd.op = pns_pkg::OP_MAG;
      pns_pkg::ST_GNW:   cmd.op = pns_pkg::OP_GNW;
      pns_pkg::ST_MX:    cmd.op = pns_pkg::OP_MX;
      pns_pkg::ST_KINIT: cmd.op = pns_pkg::OP_KINIT;
      pns_pkg::ST_KRED:  cmd.op = pns_pkg::OP_KRED;
      pns_pkg::ST_RINIT: cmd.op = pns_pkg::OP_RINIT;
      pns_pkg::ST_TM:    cmd.op = pns_pkg::OP_TM;
      pns_pkg::ST_DIVS:  cmd.op = pns_pkg::OP_DIVS;
      pns_pkg::ST_DIV:   cmd.op = pns_pkg::OP_DIV;
      pns_pkg::ST_TADD:  cmd.op = pns_pkg::OP_TADD;
      pns_pkg::ST_EXPO:  cmd.op = pns_pkg::OP_EXPO;
      pns_pkg::ST_GM:    cmd.op = pns_pkg::OP_GM;
      pns_pkg::ST_GW:    cmd.op = pns_pkg::OP_GW;
      pns_pkg::ST_TW:    cmd.op = pns_pkg::OP_TW;
      pns_pkg::ST_RH:    cmd.op = pns_pkg::OP_RH;
      pns_pkg::ST_RL:    cmd.op = pns_pkg::OP_RL;
      // hold the final write until the output register is free
      pns_pkg::ST_RW:    if (out_free) cmd.op = pns_pkg::OP_RW;
      default:           cmd.op = pns_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == pns_pkg::ST_RW && out_free) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pns_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/pns_dp.sv
// Datapath of the perception noise step: config registers, noise state,
// one shared 33x33 multiplier, range reduction, radix-16 divider, output register.
// Depends on pns_pkg.
module pns_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [2:0]                cfg_index,
  input  logic [23:0]               cfg_wdata,
  input  logic [pns_pkg::IN_W-1:0]  in_tdata,
  output logic [pns_pkg::OUT_W-1:0] out_tdata,
  input  pns_pkg::cmd_t             cmd,
  output pns_pkg::status_t          stat
);

  logic        en_r;
  logic [15:0] dgap_r, drate_r;
  logic [23:0] agap_r, arate_r, aacc_r, gvc_r, ittc_r;

  logic signed [23:0] ngap_r, nrate_r;
  logic signed [31:0] nacc_r, hgap_r, hspd_r, hrate_r;
  logic signed [16:0] ca_r, cr_r, cg_r;
  logic               upd_acc_r, upd_rate_r, upd_gap_r;

  logic signed [65:0] prod_r;
  logic signed [49:0] tmp_r;
  logic               hi_r, lo_r;
  logic signed [50:0] v_r;
  logic signed [5:0]  k_r;
  logic signed [31:0] r_r, term_r, e_r, gerr_r;
  logic signed [63:0] sum_r;
  logic [3:0]         n_r, rem_r;
  logic [31:0]        dq_r;
  logic               dneg_r;
  logic [2:0]         dcnt_r;
  logic signed [40:0] t_r;
  logic signed [31:0] oacc_r, ogerr_r, orerr_r;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic               mul_en;
  logic signed [65:0] p16, p32;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      pns_pkg::OP_MA:  begin mul_a = $signed({9'd0, aacc_r});   mul_b = 33'(ca_r);    end
      pns_pkg::OP_MDR: begin mul_a = $signed({17'd0, drate_r}); mul_b = 33'(nrate_r); end
      pns_pkg::OP_MAR: begin mul_a = $signed({9'd0, arate_r});  mul_b = 33'(cr_r);    end
      pns_pkg::OP_MDG: begin mul_a = $signed({17'd0, dgap_r});  mul_b = 33'(ngap_r);  end
      pns_pkg::OP_MAG: begin mul_a = $signed({9'd0, agap_r});   mul_b = 33'(cg_r);    end
      pns_pkg::OP_MX:  begin mul_a = $signed({9'd0, gvc_r});    mul_b = 33'(ngap_r);  end
      pns_pkg::OP_TM:  begin mul_a = 33'(term_r);               mul_b = 33'(r_r);     end
      pns_pkg::OP_GM:  begin mul_a = 33'(hgap_r);               mul_b = 33'(e_r);     end
      pns_pkg::OP_GW:  begin mul_a = 33'(hgap_r);               mul_b = $signed({9'd0, ittc_r}); end
      pns_pkg::OP_RH:  begin mul_a = 33'($signed(t_r[40:16]));  mul_b = 33'(nrate_r); end
      pns_pkg::OP_RL:  begin mul_a = $signed({17'd0, t_r[15:0]}); mul_b = 33'(nrate_r); end
      default:         mul_en = 1'b0;
    endcase
  end

  // Round to nearest, ties upward
  assign p16 = (prod_r + 66'sd32768) >>> 16;
  assign p32 = (prod_r + 66'sd2147483648) >>> 32;

  // AR noise sum and saturation
  logic signed [26:0] ar_sum;
  logic signed [23:0] ar_sat;
  assign ar_sum = tmp_r[26:0] + $signed(p16[26:0]);
  always_comb begin
    if (ar_sum > 27'sd8388607)       ar_sat = 24'sh7FFFFF;
    else if (ar_sum < -27'sd8388608) ar_sat = 24'sh800000;
    else                             ar_sat = ar_sum[23:0];
  end

  // Range reduction
  logic signed [33:0] xv;
  logic signed [50:0] v_init;
  assign xv     = $signed(p16[33:0]);
  assign v_init = $signed({xv, 16'd0}) + pns_pkg::HALF_LN2;
  assign stat.kdone = hi_r || lo_r || (!v_r[50] && (v_r < pns_pkg::LN2_Q32));

  // Divider: four quotient bits a cycle
  logic [4:0]  rem5;
  logic [3:0]  rem_w;
  logic [31:0] dq_w;
  always_comb begin
    rem_w = rem_r;
    dq_w  = dq_r;
    rem5  = '0;
    for (int i = 0; i < 4; i++) begin
      rem5 = {rem_w, dq_w[31]};
      dq_w = {dq_w[30:0], 1'b0};
      if (rem5 >= {1'b0, n_r}) begin
        rem5    = rem5 - {1'b0, n_r};
        dq_w[0] = 1'b1;
      end
      rem_w = rem5[3:0];
    end
  end
  assign stat.div_last  = (dcnt_r == 3'd7);
  assign stat.term_last = (n_r == pns_pkg::N_LAST);

  logic signed [31:0] div_a, qs;
  assign div_a = $signed(p32[31:0]);
  assign qs    = dneg_r ? -$signed(dq_r) : $signed(dq_r);

  // Exponential reconstruction
  logic signed [63:0] m, ms, ed;
  logic [5:0]         km;
  logic signed [31:0] e_nxt;
  always_comb begin
    m  = pns_pkg::ONE_Q32 + sum_r;
    km = 6'(-k_r);
    if (!k_r[5]) ms = m <<< k_r[4:0];
    else         ms = (m + (64'sd1 <<< (km[4:0] - 5'd1))) >>> km[4:0];
    ed = (ms - pns_pkg::ONE_Q32 + 64'sd32768) >>> 16;
    if (hi_r)                         e_nxt = 32'sh7FFFFFFF;
    else if (lo_r)                    e_nxt = -32'sd65536;
    else if (ed > 64'sd2147483647)    e_nxt = 32'sh7FFFFFFF;
    else if (ed < -64'sd2147483648)   e_nxt = 32'sh80000000;
    else                              e_nxt = ed[31:0];
  end

  logic signed [31:0] gsat;
  always_comb begin
    if (p16 > 66'sd2147483647)       gsat = 32'sh7FFFFFFF;
    else if (p16 < -66'sd2147483648) gsat = 32'sh80000000;
    else                             gsat = p16[31:0];
  end

  // Rate error with clamp to speed minus rate
  logic signed [49:0] rerr, lim50, rclamp;
  logic signed [32:0] lim;
  logic signed [31:0] rsat;
  always_comb begin
    rerr   = tmp_r + $signed(p16[49:0]);
    lim    = 33'(hspd_r) - 33'(hrate_r);
    lim50  = 50'(lim);
    rclamp = (rerr > lim50) ? lim50 : rerr;
    if (rclamp > 50'sd2147483647)       rsat = 32'sh7FFFFFFF;
    else if (rclamp < -50'sd2147483648) rsat = 32'sh80000000;
    else                                rsat = rclamp[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b1;
      dgap_r  <= '0;
      drate_r <= '0;
      agap_r  <= '0;
      arate_r <= '0;
      aacc_r  <= '0;
      gvc_r   <= '0;
      ittc_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pns_pkg::REG_ENABLE:     en_r    <= cfg_wdata[0];
        pns_pkg::REG_DECAY_GAP:  dgap_r  <= cfg_wdata[15:0];
        pns_pkg::REG_DECAY_RATE: drate_r <= cfg_wdata[15:0];
        pns_pkg::REG_AMP_GAP:    agap_r  <= cfg_wdata;
        pns_pkg::REG_AMP_RATE:   arate_r <= cfg_wdata;
        pns_pkg::REG_AMP_ACCEL:  aacc_r  <= cfg_wdata;
        pns_pkg::REG_GAP_VAR:    gvc_r   <= cfg_wdata;
        pns_pkg::REG_INV_TTC:    ittc_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Noise and held kinematic state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ngap_r  <= '0;
      nrate_r <= '0;
      nacc_r  <= '0;
      hgap_r  <= pns_pkg::HELD_INIT;
      hspd_r  <= pns_pkg::HELD_INIT;
      hrate_r <= '0;
    end else begin
      if (cmd.op == pns_pkg::OP_LOAD && en_r) begin
        hgap_r  <= $signed(in_tdata[31:0]);
        hspd_r  <= $signed(in_tdata[63:32]);
        hrate_r <= $signed(in_tdata[95:64]);
      end
      if (cmd.op == pns_pkg::OP_MDR && upd_acc_r) nacc_r <= p16[31:0];
      if (cmd.op == pns_pkg::OP_MDG && upd_rate_r) nrate_r <= ar_sat;
      if (cmd.op == pns_pkg::OP_GNW && upd_gap_r) ngap_r <= ar_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      pns_pkg::OP_LOAD: begin
        ca_r       <= $signed({1'b0, in_tdata[111:96]}) - pns_pkg::C_BIAS;
        cr_r       <= $signed({1'b0, in_tdata[127:112]}) - pns_pkg::C_BIAS;
        cg_r       <= $signed({1'b0, in_tdata[143:128]}) - pns_pkg::C_BIAS;
        upd_acc_r  <= en_r && (aacc_r != '0);
        upd_rate_r <= en_r && (ittc_r != '0);
        upd_gap_r  <= en_r && (gvc_r != '0);
      end
      pns_pkg::OP_MAR, pns_pkg::OP_MAG: tmp_r <= p16[49:0];
      pns_pkg::OP_KINIT: begin
        hi_r <= xv > pns_pkg::X_HI;
        lo_r <= xv < pns_pkg::X_LO;
        v_r  <= v_init;
        k_r  <= '0;
      end
      pns_pkg::OP_KRED: begin
        if (!stat.kdone) begin
          if (v_r[50]) begin
            v_r <= v_r + pns_pkg::LN2_Q32;
            k_r <= k_r - 6'sd1;
          end else begin
            v_r <= v_r - pns_pkg::LN2_Q32;
            k_r <= k_r + 6'sd1;
          end
        end
      end
      pns_pkg::OP_RINIT: begin
        r_r    <= 32'(v_r - pns_pkg::HALF_LN2);
        term_r <= 32'(v_r - pns_pkg::HALF_LN2);
        sum_r  <= 64'(v_r - pns_pkg::HALF_LN2);
        n_r    <= pns_pkg::N_FIRST;
      end
      pns_pkg::OP_DIVS: begin
        dneg_r <= div_a[31];
        dq_r   <= div_a[31] ? 32'(-div_a) : div_a;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      pns_pkg::OP_DIV: begin
        dq_r   <= dq_w;
        rem_r  <= rem_w;
        dcnt_r <= dcnt_r + 3'd1;
      end
      pns_pkg::OP_TADD: begin
        term_r <= qs;
        sum_r  <= sum_r + 64'(qs);
        n_r    <= n_r + 4'd1;
      end
      pns_pkg::OP_EXPO: e_r <= e_nxt;
      pns_pkg::OP_GW:   gerr_r <= gsat;
      pns_pkg::OP_TW:   t_r <= p16[40:0];
      pns_pkg::OP_RL:   tmp_r <= prod_r[49:0];
      pns_pkg::OP_RW: begin
        oacc_r  <= nacc_r;
        ogerr_r <= gerr_r;
        orerr_r <= rsat;
      end
      default: ;
    endcase
  end

  assign out_tdata = {orerr_r, ogerr_r, oacc_r};

endmodule

### rtl/core/perception_noise_step.sv
// Top level of the perception noise step: sequencer plus datapath.
// Depends on pns_pkg, pns_ctrl and pns_dp.
//
//  channel | dir | fields (lowest bit first)
//  in_     | in  | gap, speed, approach_rate, rand_accel, rand_rate, rand_gap
//  out_    | out | accel_noise, gap_error, rate_error
//  cfg_    | in  | register index 0..7, write data
//
// One item runs through 18 fixed sequencer steps (the first range reduction check
// included), one more reduction step per ln2 of range reduction (up to 17), and
// eleven series terms, each a multiply, a sign set-up, the radix-16 divider passes
// and an accumulate; the term divider takes most of an item's time.
// Reset is synchronous, active low.
// The next item is taken while the previous result waits in the output register;
// a stalled output holds the sequencer only at its final write.
module perception_noise_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // gap[31:0], speed[63:32], approach_rate[95:64], rand_accel[111:96],
  // rand_rate[127:112], rand_gap[143:128]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // accel_noise[31:0], gap_error[63:32], rate_error[95:64]
  output logic [95:0]  out_tdata,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  pns_pkg::cmd_t    cmd;
  pns_pkg::status_t stat;

  pns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pns_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
